// ===== sv/bit_pkg.sv =====
// ----------------------------------------------------------------------------
// bit_pkg
// Shared types and constants for the binary image thinning block.
// ----------------------------------------------------------------------------
package bit_pkg;

    localparam int MAX_HEIGHT = 512;
    localparam int MAX_WIDTH  = 512;
    localparam int DIM_W      = 10;
    localparam int ADDR_W     = $clog2(MAX_HEIGHT * MAX_WIDTH);
    localparam int TOT_W      = ADDR_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // category codes
    localparam logic [7:0] CAT_U  = 8'o010;
    localparam logic [7:0] CAT_E  = 8'o020;
    localparam logic [7:0] CAT_I  = 8'o040;
    localparam logic [7:0] CAT_MM = 8'o100;
    localparam logic [7:0] CAT_M  = 8'o200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEIGHT     = 3'd0,
        REG_WIDTH      = 3'd1,
        REG_THIN       = 3'd2,
        REG_DIAGONAL   = 3'd3,
        REG_CATEGORIZE = 3'd4,
        REG_SINGLE     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PASS_THIN = 2'd0,
        PASS_DIAG = 2'd1,
        PASS_CAT  = 2'd2
    } pass_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_C_RD,
        ST_C_CAP,
        ST_N_RD,
        ST_N_CAP,
        ST_EVAL,
        ST_SCAN_END
    } state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_in;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_out;
    } out_item_t;

endpackage

// ===== sv/binary_image_thinning.sv =====
// ----------------------------------------------------------------------------
// binary_image_thinning
// Stores an edge image, thins it in place in raster order, optionally
// categorizes points, then streams the result back on request.
// ----------------------------------------------------------------------------
// Load transactions use mode 0. A read transaction (mode 1) takes its pixel
// from the image memory's registered read port, and the input side holds off
// until the result has been taken. The load transaction flagged last_in starts
// processing if any pass is enabled, and input is stalled meanwhile. Each scan
// visits every pixel in raster order: a background pixel passes C_RD and
// C_CAP; a foreground pixel then visits its eight neighbors in N_RD, with an
// N_CAP for each in-frame neighbor, and ends in EVAL; each scan ends in
// SCAN_END. Thin and diagonal scans repeat until one deletes nothing unless
// single_pass is set. Memory contents after reset are undefined until loaded.
module binary_image_thinning (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  bit_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bit_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [bit_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bit_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = bit_pkg::ADDR_W;
    localparam int TW = bit_pkg::TOT_W;
    localparam int DW = bit_pkg::DIM_W;

    // configuration
    logic [DW-1:0] height_reg, width_reg;
    logic          thin_en_reg, diag_en_reg, cat_en_reg, single_reg;

    // control
    bit_pkg::state_t state_reg, state_next;
    bit_pkg::pass_t  pass_reg, pass_next;
    logic            changed_reg, changed_next;
    logic [TW-1:0]   load_pos_reg, load_pos_next;
    logic [TW-1:0]   read_pos_reg, read_pos_next;
    logic [DW-1:0]   row_reg, row_next, col_reg, col_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [2:0]      dir_reg, dir_next;
    logic [7:0]      ring_reg, ring_next;
    logic            out_valid_reg, out_valid_next;
    logic            last_reg, last_next;

    // memory
    logic [7:0]    mem [2**AW];
    logic [7:0]    rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic [DW-1:0] eff_h, eff_w;
    logic [TW-1:0] total;
    logic          in_acc, out_acc;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        if (v == '0)
            return DW'(1);
        else if (v > DW'(bit_pkg::MAX_HEIGHT))
            return DW'(bit_pkg::MAX_HEIGHT);
        else
            return v;
    endfunction

    function automatic logic [DW-1:0] clamp_w(input logic [DW-1:0] v);
        if (v == '0)
            return DW'(1);
        else if (v > DW'(bit_pkg::MAX_WIDTH))
            return DW'(bit_pkg::MAX_WIDTH);
        else
            return v;
    endfunction

    assign eff_h = clamp_dim(height_reg);
    assign eff_w = clamp_w(width_reg);
    assign total = TW'(eff_h) * TW'(eff_w);

    assign in_stall  = (state_reg != bit_pkg::ST_IDLE) || out_valid_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_data.pixel_out = rdata_reg;
    assign out_data.last_out  = last_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg  <= DW'(512);
            width_reg   <= DW'(512);
            thin_en_reg <= 1'b1;
            diag_en_reg <= 1'b1;
            cat_en_reg  <= 1'b0;
            single_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bit_pkg::REG_HEIGHT:     height_reg  <= cfg_data;
                bit_pkg::REG_WIDTH:      width_reg   <= cfg_data;
                bit_pkg::REG_THIN:       thin_en_reg <= cfg_data[0];
                bit_pkg::REG_DIAGONAL:   diag_en_reg <= cfg_data[0];
                bit_pkg::REG_CATEGORIZE: cat_en_reg  <= cfg_data[0];
                bit_pkg::REG_SINGLE:     single_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ring statistics of the captured neighborhood
    logic [3:0] neigh, trans;
    logic [2:0] last_e, gaps;
    logic       open_gap;
    logic [2:0] e;
    logic       del_thin, skip_diag, del_diag;
    logic [7:0] cat_code;

    always_comb
    begin
        neigh = 4'($countones(ring_reg));
        trans = 4'($countones(ring_reg ^ {ring_reg[0], ring_reg[7:1]}));
        last_e = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (ring_reg[i])
                last_e = 3'(i);
        end
        // walk the ring after the last set neighbor; gaps open on 4-sides
        gaps = 3'd0;
        open_gap = 1'b0;
        e = last_e;
        for (int i = 1; i < 8; i++)
        begin
            e = e + 3'd1;
            if (open_gap)
            begin
                if (ring_reg[e])
                    open_gap = 1'b0;
            end
            else if (!e[0] && !ring_reg[e])
            begin
                open_gap = 1'b1;
                gaps = gaps + 3'd1;
            end
        end
        del_thin  = (trans == 4'd2) && (neigh > 4'd2) && (neigh < 4'd6);
        skip_diag = (neigh < 4'd2) || (neigh > 4'd6) ||
                    ((neigh == 4'd2) && (trans < 4'd4)) ||
                    ((neigh == 4'd3) && (trans > 4'd4));
        del_diag  = !skip_diag && (gaps == 3'd1);
        priority if ((trans == 4'd2) && (neigh < 4'd3))
            cat_code = bit_pkg::CAT_E;
        else if (neigh == 4'd0)
            cat_code = bit_pkg::CAT_I;
        else if (trans >= 4'd6)
            cat_code = bit_pkg::CAT_M;
        else if (neigh > 4'd2)
            cat_code = bit_pkg::CAT_MM;
        else
            cat_code = bit_pkg::CAT_U;
    end

    // neighbor in frame and its address; direction dir_reg around the ring
    logic          nb_in;
    logic [TW-1:0] nb_addr;
    logic          row_up, row_dn, col_lf, col_rt;

    always_comb
    begin
        row_up = (row_reg != '0);
        row_dn = ((row_reg + DW'(1)) < eff_h);
        col_lf = (col_reg != '0);
        col_rt = ((col_reg + DW'(1)) < eff_w);
        unique case (dir_reg)
            3'd0:
            begin
                nb_in   = col_rt;
                nb_addr = TW'(pos_reg) + TW'(1);
            end
            3'd1:
            begin
                nb_in   = row_up && col_rt;
                nb_addr = TW'(pos_reg) - TW'(eff_w) + TW'(1);
            end
            3'd2:
            begin
                nb_in   = row_up;
                nb_addr = TW'(pos_reg) - TW'(eff_w);
            end
            3'd3:
            begin
                nb_in   = row_up && col_lf;
                nb_addr = TW'(pos_reg) - TW'(eff_w) - TW'(1);
            end
            3'd4:
            begin
                nb_in   = col_lf;
                nb_addr = TW'(pos_reg) - TW'(1);
            end
            3'd5:
            begin
                nb_in   = row_dn && col_lf;
                nb_addr = TW'(pos_reg) + TW'(eff_w) - TW'(1);
            end
            3'd6:
            begin
                nb_in   = row_dn;
                nb_addr = TW'(pos_reg) + TW'(eff_w);
            end
            default:
            begin
                nb_in   = row_dn && col_rt;
                nb_addr = TW'(pos_reg) + TW'(eff_w) + TW'(1);
            end
        endcase
    end

    // pass selection: first enabled pass at or after start
    logic [1:0] pass_start;
    logic       pass_found;
    bit_pkg::pass_t pass_pick;
    logic       repeat_scan;
    logic       last_px;
    logic       rd_wrap;
    logic [TW-1:0] rd_addr;

    always_comb
    begin
        pass_found = 1'b1;
        pass_pick  = bit_pkg::PASS_THIN;
        priority if ((pass_start == 2'd0) && thin_en_reg)
            pass_pick = bit_pkg::PASS_THIN;
        else if ((pass_start <= 2'd1) && diag_en_reg)
            pass_pick = bit_pkg::PASS_DIAG;
        else if ((pass_start <= 2'd2) && cat_en_reg)
            pass_pick = bit_pkg::PASS_CAT;
        else
            pass_found = 1'b0;
    end

    assign pass_start  = (state_reg == bit_pkg::ST_SCAN_END) ?
                         (2'(pass_reg) + 2'd1) : 2'd0;
    assign repeat_scan = changed_reg && !single_reg && (pass_reg != bit_pkg::PASS_CAT);
    assign last_px     = ((row_reg + DW'(1)) == eff_h) && ((col_reg + DW'(1)) == eff_w);
    assign rd_wrap     = (read_pos_reg >= total);
    assign rd_addr     = rd_wrap ? '0 : read_pos_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bit_pkg::ST_IDLE:
            begin
                if (in_acc && in_data.mode)
                    state_next = bit_pkg::ST_RD_WAIT;
                else if (in_acc && in_data.last_in && pass_found)
                    state_next = bit_pkg::ST_C_RD;
            end
            bit_pkg::ST_RD_WAIT:
                state_next = bit_pkg::ST_IDLE;
            bit_pkg::ST_C_RD:
                state_next = bit_pkg::ST_C_CAP;
            bit_pkg::ST_C_CAP:
            begin
                if (rdata_reg != '0)
                    state_next = bit_pkg::ST_N_RD;
                else if (last_px)
                    state_next = bit_pkg::ST_SCAN_END;
                else
                    state_next = bit_pkg::ST_C_RD;
            end
            bit_pkg::ST_N_RD:
            begin
                if (nb_in)
                    state_next = bit_pkg::ST_N_CAP;
                else if (dir_reg == 3'd7)
                    state_next = bit_pkg::ST_EVAL;
            end
            bit_pkg::ST_N_CAP:
                state_next = (dir_reg == 3'd7) ? bit_pkg::ST_EVAL : bit_pkg::ST_N_RD;
            bit_pkg::ST_EVAL:
                state_next = last_px ? bit_pkg::ST_SCAN_END : bit_pkg::ST_C_RD;
            bit_pkg::ST_SCAN_END:
            begin
                if (repeat_scan || pass_found)
                    state_next = bit_pkg::ST_C_RD;
                else
                    state_next = bit_pkg::ST_IDLE;
            end
            default:
                state_next = bit_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = pos_reg;
        pass_next      = pass_reg;
        changed_next   = changed_reg;
        load_pos_next  = load_pos_reg;
        read_pos_next  = read_pos_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pos_next       = pos_reg;
        dir_next       = dir_reg;
        ring_next      = ring_reg;
        out_valid_next = out_valid_reg && !out_acc;
        last_next      = last_reg;
        unique case (state_reg)
            bit_pkg::ST_IDLE:
            begin
                if (in_acc && in_data.mode)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = rd_addr[AW-1:0];
                    last_next     = (rd_addr == total - TW'(1));
                    read_pos_next = ((rd_addr + TW'(1)) >= total) ? '0 : rd_addr + TW'(1);
                end
                else if (in_acc)
                begin
                    if (load_pos_reg < total)
                    begin
                        mem_we        = 1'b1;
                        mem_waddr     = load_pos_reg[AW-1:0];
                        mem_wdata     = in_data.pixel_in;
                        load_pos_next = load_pos_reg + TW'(1);
                    end
                    if (in_data.last_in)
                    begin
                        load_pos_next = '0;
                        read_pos_next = '0;
                        pass_next     = pass_pick;
                        changed_next  = 1'b0;
                        row_next      = '0;
                        col_next      = '0;
                        pos_next      = '0;
                    end
                end
            end
            bit_pkg::ST_RD_WAIT:
                out_valid_next = 1'b1;
            bit_pkg::ST_C_RD:
                mem_re = 1'b1;
            bit_pkg::ST_C_CAP:
            begin
                dir_next = 3'd0;
                if (rdata_reg == '0)
                begin
                    pos_next = pos_reg + AW'(1);
                    if ((col_reg + DW'(1)) == eff_w)
                    begin
                        col_next = '0;
                        row_next = row_reg + DW'(1);
                    end
                    else
                        col_next = col_reg + DW'(1);
                end
            end
            bit_pkg::ST_N_RD:
            begin
                if (nb_in)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = nb_addr[AW-1:0];
                end
                else
                begin
                    ring_next[dir_reg] = 1'b0;
                    dir_next = dir_reg + 3'd1;
                end
            end
            bit_pkg::ST_N_CAP:
            begin
                ring_next[dir_reg] = (rdata_reg != '0);
                dir_next = dir_reg + 3'd1;
            end
            bit_pkg::ST_EVAL:
            begin
                unique case (pass_reg)
                    bit_pkg::PASS_THIN:
                    begin
                        mem_we = del_thin;
                        if (del_thin)
                            changed_next = 1'b1;
                    end
                    bit_pkg::PASS_DIAG:
                    begin
                        mem_we = del_diag;
                        if (del_diag)
                            changed_next = 1'b1;
                    end
                    default:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = cat_code;
                    end
                endcase
                pos_next = pos_reg + AW'(1);
                if ((col_reg + DW'(1)) == eff_w)
                begin
                    col_next = '0;
                    row_next = row_reg + DW'(1);
                end
                else
                    col_next = col_reg + DW'(1);
            end
            bit_pkg::ST_SCAN_END:
            begin
                row_next     = '0;
                col_next     = '0;
                pos_next     = '0;
                changed_next = 1'b0;
                if (!repeat_scan)
                    pass_next = pass_pick;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bit_pkg::ST_IDLE;
            pass_reg      <= bit_pkg::PASS_THIN;
            changed_reg   <= 1'b0;
            load_pos_reg  <= '0;
            read_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            changed_reg   <= changed_next;
            load_pos_reg  <= load_pos_next;
            read_pos_reg  <= read_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        pos_reg  <= pos_next;
        dir_reg  <= dir_next;
        ring_reg <= ring_next;
        last_reg <= last_next;
    end

    // image memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

endmodule
